/* hw/rtl/ohash_pkg.sv */
package ohash_pkg;

    localparam int KEY_W    = 16;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COEFF_W  = 4;
    localparam int CFG_IDX_W = 1;

    // request kinds (s_tuser)
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // result codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAD   = 1'd1;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_HASH,
        FSM_INSERT,
        FSM_SEARCH,
        FSM_DONE
    } fsm_state_t;

endpackage

/* hw/rtl/ohash_keymem.sv */
module ohash_keymem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [ohash_pkg::KEY_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [ohash_pkg::KEY_W-1:0] rdata
);
    import ohash_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/open_addressing_hash_table.sv */
// Open-addressing hash table of TABLE_SIZE 16-bit keys. A request on the slave
// stream (kind in s_tuser: clear, insert or search; key in s_tdata) gives one
// response on the master stream (status in m_tuser, slot in m_tdata); a request
// of the unused kind is dropped with no response. One request is worked on at a
// time and s_tready is low meanwhile; a finished response sits in an output
// register so the next request can be taken while it waits. Insert and search
// first reduce the key modulo TABLE_SIZE one nibble per cycle, then insert
// probes one slot per cycle through modular adders and search reads the key
// RAM once per cycle, home slot first, then every slot in order. Probe slot j
// is (home + c1*j + c2*j*j) mod TABLE_SIZE, with c1/c2 set through the config
// port (index 0: c1, reset 1; index 1: c2, reset 0). Config writes are meant
// for idle periods only. Clear drops valid bits only; coefficients are kept.
module open_addressing_hash_table #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] key
    input  logic [ohash_pkg::OP_W-1:0]        s_tuser,   // [1:0] op
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [3:0] slot_index, [7:4] zero
    output logic [ohash_pkg::STATUS_W-1:0]    m_tuser,   // [2:0] status
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ohash_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ohash_pkg::COEFF_W-1:0]     cfg_data
);
    import ohash_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = IDX_W + 1;

    // ---- modular helpers (narrow, constant modulus) ----

    // a + b mod N, both operands already below N
    function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(TABLE_SIZE))
        begin
            s = s - (IDX_W+1)'(TABLE_SIZE);
        end
        return s[IDX_W-1:0];
    endfunction

    // small value (< 32) mod N by restoring subtraction
    function automatic logic [IDX_W-1:0] red_mod(input logic [4:0] x);
        logic [10:0] t;
        t = {6'd0, x};
        for (int k = 4; k >= 0; k--)
        begin
            if (t >= 11'(TABLE_SIZE << k))
            begin
                t = t - 11'(TABLE_SIZE << k);
            end
        end
        return t[IDX_W-1:0];
    endfunction

    // fold one key nibble into the running remainder
    function automatic logic [IDX_W-1:0] nib_mod(input logic [IDX_W-1:0] rem,
                                                 input logic [3:0] nib);
        logic [IDX_W:0] r;
        r = {1'b0, rem};
        for (int i = 3; i >= 0; i--)
        begin
            r = {r[IDX_W-1:0], nib[i]};
            if (r >= (IDX_W+1)'(TABLE_SIZE))
            begin
                r = r - (IDX_W+1)'(TABLE_SIZE);
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // ---- state ----
    fsm_state_t              state_reg, state_next;
    logic [COEFF_W-1:0]      c1_reg, c2_reg;
    logic [OP_W-1:0]         op_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [1:0]              nib_cnt_reg;
    logic [IDX_W-1:0]        h_reg;        // remainder, then current probe slot
    logic [IDX_W-1:0]        d_reg;        // next probe step, mod N
    logic [IDX_W-1:0]        dd_reg;       // 2*c2 mod N
    logic [IDX_W-1:0]        j_reg;        // probe count
    logic [CNT_W-1:0]        scan_reg;     // 0: home read, k: slot k-1 read
    logic                    cmp_en_reg;
    logic [IDX_W-1:0]        cmp_idx_reg;
    logic [TABLE_SIZE-1:0]   valid_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic [IDX_W-1:0]        res_idx_reg;
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [SLOT_W-1:0]       out_idx_reg;

    // ---- control ----
    logic                    in_xfer;
    logic                    mem_we;
    logic                    scan_issue;
    logic [IDX_W-1:0]        mem_raddr;
    logic [KEY_W-1:0]        mem_rdata;
    logic                    hit;
    logic                    out_load;
    logic                    last_probe;
    logic                    scan_end;
    logic [3:0]              key_nib;
    logic [IDX_W+3:0]        res_idx_ext;

    assign cfg_ready = 1'b1;

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = (state_reg == FSM_IDLE);
        mem_we     = (state_reg == FSM_INSERT) && !valid_reg[h_reg];
        scan_issue = (state_reg == FSM_SEARCH) && (scan_reg <= CNT_W'(TABLE_SIZE));
        mem_raddr  = (scan_reg == '0) ? h_reg : IDX_W'(scan_reg - CNT_W'(1));
        hit        = cmp_en_reg && valid_reg[cmp_idx_reg] && (mem_rdata == key_reg);
        out_load   = (state_reg == FSM_DONE) && (!out_valid_reg || m_tready);
        last_probe = (j_reg == IDX_W'(TABLE_SIZE - 1));
        scan_end   = (scan_reg == CNT_W'(TABLE_SIZE + 1));
    end

    assign in_xfer = s_tvalid && s_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_xfer)
                begin
                    case (s_tuser)
                        OP_CLEAR:  state_next = FSM_DONE;
                        OP_INSERT: state_next = FSM_HASH;
                        OP_SEARCH: state_next = FSM_HASH;
                        default:   state_next = FSM_IDLE;   // unused kind: dropped
                    endcase
                end
            end
            FSM_HASH:
            begin
                if (nib_cnt_reg == 2'd3)
                begin
                    state_next = (op_reg == OP_INSERT) ? FSM_INSERT : FSM_SEARCH;
                end
            end
            FSM_INSERT:
            begin
                if (!valid_reg[h_reg] || last_probe)
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_SEARCH:
            begin
                if (hit || scan_end)
                begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE:
            begin
                if (out_load)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // key nibble, most significant first
    always_comb
    begin
        case (nib_cnt_reg)
            2'd0:    key_nib = key_reg[15:12];
            2'd1:    key_nib = key_reg[11:8];
            2'd2:    key_nib = key_reg[7:4];
            default: key_nib = key_reg[3:0];
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            c1_reg        <= COEFF_W'(1);
            c2_reg        <= '0;
            valid_reg     <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LINEAR: c1_reg <= cfg_data;
                    CFG_QUAD:   c2_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (in_xfer && (s_tuser == OP_CLEAR))
            begin
                valid_reg <= '0;
            end
            else if (mem_we)
            begin
                valid_reg[h_reg] <= 1'b1;
            end
            cmp_en_reg <= scan_issue;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= mem_raddr;
        if (in_xfer)
        begin
            op_reg      <= s_tuser;
            key_reg     <= s_tdata;
            nib_cnt_reg <= 2'd0;
            h_reg       <= '0;
            j_reg       <= '0;
            scan_reg    <= '0;
            // first step c1 + c2, then grows by 2*c2 each probe
            d_reg       <= add_mod(red_mod({1'b0, c1_reg}), red_mod({1'b0, c2_reg}));
            dd_reg      <= red_mod({c2_reg, 1'b0});
            res_status_reg <= ST_CLEARED;
            res_idx_reg    <= '0;
        end
        case (state_reg)
            FSM_HASH:
            begin
                h_reg       <= nib_mod(h_reg, key_nib);
                nib_cnt_reg <= nib_cnt_reg + 2'd1;
            end
            FSM_INSERT:
            begin
                if (!valid_reg[h_reg])
                begin
                    res_status_reg <= ST_INSERTED;
                    res_idx_reg    <= h_reg;
                end
                else
                begin
                    if (last_probe)
                    begin
                        res_status_reg <= ST_FULL;
                        res_idx_reg    <= '0;
                    end
                    h_reg <= add_mod(h_reg, d_reg);
                    d_reg <= add_mod(d_reg, dd_reg);
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
            FSM_SEARCH:
            begin
                scan_reg <= scan_reg + CNT_W'(1);
                if (hit)
                begin
                    res_status_reg <= ST_FOUND;
                    res_idx_reg    <= cmp_idx_reg;
                end
                else if (scan_end)
                begin
                    res_status_reg <= ST_NOT_FOUND;
                    res_idx_reg    <= '0;
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_ext[SLOT_W-1:0];
        end
    end

    assign res_idx_ext = {4'd0, res_idx_reg};

    ohash_keymem #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W)
    ) u_keymem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (h_reg),
        .wdata (key_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_idx_reg};

endmodule
